/* rtl/fully_associative_lru_cache_directory_macros.svh */
// assertion macros for the lru cache directory
// no dependencies
`ifndef FULLY_ASSOCIATIVE_LRU_CACHE_DIRECTORY_MACROS_SVH
`define FULLY_ASSOCIATIVE_LRU_CACHE_DIRECTORY_MACROS_SVH

// implication checked on every clock edge outside reset
`define FALRU_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define FALRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/falru_pkg.sv */
// shared constants and types for the lru cache directory
// no dependencies
`timescale 1ns / 1ps

package falru_pkg;

    localparam int unsigned Lines      = 512;
    localparam int unsigned OffsetBits = 6;
    localparam int unsigned IdxW       = $clog2(Lines);
    localparam int unsigned CntW       = $clog2(Lines + 1);
    localparam int unsigned TagW       = 32 - OffsetBits;
    localparam int unsigned OutIdxW    = 9;

    // controller states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_UPD    = 6'b001000,
        ST_FLUSH  = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

endpackage

/* rtl/fully_associative_lru_cache_directory.sv */
// fully associative tag directory with true lru replacement
// depends on falru_pkg and the assertion macro header
//
// usage:
//   s_axis carries one 32-bit byte address per transaction in s_axis_tdata.
//   m_axis returns one result per address: tdata bits [0] hit, [9:1] line,
//   [41:10] hit total, [73:42] miss total, zero filled to 80 bits.
//   the tag and rank store is a single synchronous ram, one entry a cycle.
//   a miss runs a tag scan over the V valid lines (a hit ends the scan
//   early), a decide state, a rank update pass over the valid lines
//   (read-modify-write pipelined, one line a cycle), then flush and output
//   states. the next address is taken only after the block has returned
//   to idle, so it does not take a new address while one is in progress.
//   the two passes through the ram port set the time per address.
//   s_axis_tready is high only in the idle state. the result sits in an
//   output register; while the receiver stalls the block still takes and
//   processes one more address, then waits with that result until the
//   output register is free.
//   reset (aresetn low, synchronous) clears the valid count and counters;
//   the ram needs no clearing pass since lines fill in index order, so a
//   line is valid exactly when its index is below the fill count.
`timescale 1ns / 1ps
`include "fully_associative_lru_cache_directory_macros.svh"

module fully_associative_lru_cache_directory
    import falru_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // address
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // hit, line_index, hit_total, miss_total
);

    // ram entry: tag and rank
    localparam int unsigned EntW = TagW + IdxW;

    logic [EntW-1:0] mem [Lines];
    logic [EntW-1:0] rd_data_reg;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [EntW-1:0] wr_data;

    state_t          state_reg, state_next;
    logic [CntW-1:0] fill_reg;
    logic [TagW-1:0] tag_reg;
    logic [CntW-1:0] ptr_reg;     // read pointer
    logic            pend_reg;    // read issued last cycle
    logic [IdxW-1:0] pidx_reg;    // index of that read
    logic            found_reg;
    logic [IdxW-1:0] sel_reg;
    logic [IdxW-1:0] limit_reg;   // rank of hit line
    logic [IdxW-1:0] oldest_reg;
    logic [IdxW-1:0] oidx_reg;
    logic            hit_reg;
    logic            full_miss_reg;
    logic [31:0]     hit_cnt_reg, miss_cnt_reg;
    logic [79:0]     out_reg;
    logic            out_valid_reg;

    logic [TagW-1:0] rd_tag;
    logic [IdxW-1:0] rd_rank;
    logic            scan_done;
    logic            upd_done;

    assign rd_tag  = rd_data_reg[EntW-1:IdxW];
    assign rd_rank = rd_data_reg[IdxW-1:0];
    assign rd_addr = ptr_reg[IdxW-1:0];

    // synchronous ram, one read and one write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign scan_done = (ptr_reg == fill_reg) && !pend_reg;
    assign upd_done  = (ptr_reg == fill_reg) && !pend_reg;

    // rank update write-back, and the append of a new line on a miss
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pidx_reg;
        wr_data = rd_data_reg;
        if (state_reg == ST_UPD && pend_reg) begin
            wr_en = 1'b1;
            if (pidx_reg == sel_reg) begin
                wr_data = {(hit_reg ? rd_tag : tag_reg), {IdxW{1'b0}}};
            end else if (hit_reg ? (rd_rank < limit_reg) : 1'b1) begin
                wr_data = {rd_tag, rd_rank + IdxW'(1)};
            end
        end else if (state_reg == ST_FLUSH && !hit_reg && !full_miss_reg) begin
            // new line appended at the fill count
            wr_en   = 1'b1;
            wr_addr = sel_reg;
            wr_data = {tag_reg, {IdxW{1'b0}}};
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_axis_tvalid) state_next = ST_SCAN;
            ST_SCAN:   if (scan_done || (pend_reg && rd_tag == tag_reg))
                           state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_UPD;
            ST_UPD:    if (upd_done) state_next = ST_FLUSH;
            ST_FLUSH:  state_next = ST_OUT;
            ST_OUT:    if (!out_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready && state_reg != ST_OUT) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                // take the address
                ST_IDLE: begin
                    ptr_reg  <= '0;
                    pend_reg <= 1'b0;
                    if (s_axis_tvalid && s_axis_tready) begin
                        tag_reg    <= s_axis_tdata[31:OffsetBits];
                        found_reg  <= 1'b0;
                        oldest_reg <= '0;
                        oidx_reg   <= '0;
                    end
                end
                // scan valid lines for the tag, track the oldest rank
                ST_SCAN: begin
                    if (pend_reg && rd_tag == tag_reg) begin
                        found_reg <= 1'b1;
                        sel_reg   <= pidx_reg;
                        limit_reg <= rd_rank;
                        pend_reg  <= 1'b0;
                    end else begin
                        if (pend_reg && (pidx_reg == '0 || rd_rank > oldest_reg)) begin
                            oldest_reg <= rd_rank;
                            oidx_reg   <= pidx_reg;
                        end
                        pend_reg <= ptr_reg != fill_reg;
                        pidx_reg <= rd_addr;
                        if (ptr_reg != fill_reg) ptr_reg <= ptr_reg + CntW'(1);
                    end
                end
                // pick the line to use
                ST_DECIDE: begin
                    ptr_reg  <= '0;
                    pend_reg <= 1'b0;
                    hit_reg  <= found_reg;
                    full_miss_reg <= !found_reg && (fill_reg == CntW'(Lines));
                    if (!found_reg) begin
                        sel_reg <= (fill_reg == CntW'(Lines)) ? oidx_reg
                                                             : fill_reg[IdxW-1:0];
                    end
                end
                // read-modify-write pass over valid lines
                ST_UPD: begin
                    pend_reg <= ptr_reg != fill_reg;
                    pidx_reg <= rd_addr;
                    if (ptr_reg != fill_reg) ptr_reg <= ptr_reg + CntW'(1);
                end
                // append new line, update counters
                ST_FLUSH: begin
                    if (hit_reg) begin
                        if (hit_cnt_reg != '1) hit_cnt_reg <= hit_cnt_reg + 32'd1;
                    end else begin
                        if (miss_cnt_reg != '1) miss_cnt_reg <= miss_cnt_reg + 32'd1;
                        if (!full_miss_reg) fill_reg <= fill_reg + CntW'(1);
                    end
                end
                // load the output register
                ST_OUT: begin
                    if (!out_valid_reg || m_axis_tready) begin
                        out_valid_reg <= 1'b1;
                        out_reg <= {6'b0, miss_cnt_reg, hit_cnt_reg,
                                    OutIdxW'(sel_reg), hit_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    `FALRU_ASSERT(a_fill_bound, 1'b1, fill_reg <= CntW'(Lines), "fill count beyond depth")
    `FALRU_ASSERT(a_ready_idle, s_axis_tready, state_reg == ST_IDLE, "ready outside idle")
    `FALRU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped under stall")
    `FALRU_ASSERT(a_hit_sel, state_reg == ST_FLUSH && hit_reg,
        CntW'(sel_reg) < fill_reg, "hit on line beyond fill")

endmodule
